FILE: sv/gwwb_pkg.sv
package gwwb_pkg;

	// frame capacity is 2**PIXEL_COUNT_BITS pixels
	localparam int PIXEL_COUNT_BITS = 22;
	localparam int CH_W = 8;
	localparam int NUM_CH = 3;
	localparam int TOTAL_W = PIXEL_COUNT_BITS + CH_W;
	localparam int COUNT_W = PIXEL_COUNT_BITS + 1;

	// divider operand widths, wide enough for both sums and products
	localparam int PROD_W = 2 * CH_W;
	localparam int DIVD_W = (TOTAL_W > PROD_W) ? TOTAL_W : PROD_W;
	localparam int DVSR_W = (COUNT_W > CH_W) ? COUNT_W : CH_W;
	localparam int SHIFT_W = DVSR_W + CH_W;
	localparam int CMP_W = ((DIVD_W > SHIFT_W) ? DIVD_W : SHIFT_W) + 1;
	localparam int QUOT_W = CH_W + 1;
	localparam int STEP_W = $clog2(QUOT_W);

	// request queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// channel lanes
	localparam int CH_BLUE = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED = 2;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;
	localparam logic [CH_W-1:0] MEAN_RESET = 8'd128;
	localparam logic [CH_W-1:0] TARGET_RESET = 8'd128;
	localparam logic CMD_CORRECT = 1'b1;

	typedef enum logic [1:0] {
		OP_GATHER,
		OP_FINALIZE,
		OP_CORRECT
	} op_t;

	typedef struct packed {
		op_t                         op;
		logic [NUM_CH-1:0][CH_W-1:0] pix;
	} item_t;

	typedef struct packed {
		logic                          start;
		logic [NUM_CH-1:0][DIVD_W-1:0] dividend;
		logic [NUM_CH-1:0][DVSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                        done;
		logic [NUM_CH-1:0][CH_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: sv/gwwb_if.sv
interface gwwb_pix_if import gwwb_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            cmd;
	logic [CH_W-1:0] blue_in;
	logic [CH_W-1:0] green_in;
	logic [CH_W-1:0] red_in;
	logic            frame_last;

	modport source(output valid, cmd, blue_in, green_in, red_in, frame_last, input ready);
	modport sink(input valid, cmd, blue_in, green_in, red_in, frame_last, output ready);
endinterface

interface gwwb_res_if import gwwb_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] blue_out;
	logic [CH_W-1:0] green_out;
	logic [CH_W-1:0] red_out;
	logic            frame_clipped;

	modport source(output valid, blue_out, green_out, red_out, frame_clipped, input ready);
	modport sink(input valid, blue_out, green_out, red_out, frame_clipped, output ready);
endinterface

interface gwwb_cfg_if import gwwb_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] target_mean;

	modport source(output valid, target_mean, input ready);
	modport sink(input valid, target_mean, output ready);
endinterface

FILE: sv/gwwb_front.sv
module gwwb_front import gwwb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gwwb_pix_if.sink   pixel,
	output item_t      item,
	output logic       item_valid,
	input  logic       item_pop
);

	item_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	item_t              incoming;
	logic               push;
	logic               pop;

	// classify the request
	always_comb begin
		if (pixel.cmd == CMD_CORRECT) begin
			incoming.op = OP_CORRECT;
		end else if (pixel.frame_last) begin
			incoming.op = OP_FINALIZE;
		end else begin
			incoming.op = OP_GATHER;
		end
		incoming.pix[CH_BLUE]  = pixel.blue_in;
		incoming.pix[CH_GREEN] = pixel.green_in;
		incoming.pix[CH_RED]   = pixel.red_in;
	end

	assign pixel.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push = pixel.valid && pixel.ready;
	assign item_valid = (count_q != '0);
	assign pop = item_pop && item_valid;
	assign item = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= incoming;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/gwwb_div.sv
module gwwb_div import gwwb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NUM_CH-1:0][DIVD_W-1:0]  rem_q;
	logic [NUM_CH-1:0][SHIFT_W-1:0] dsh_q;
	logic [NUM_CH-1:0][QUOT_W-1:0]  quot_q;
	logic [STEP_W-1:0]              step_q;
	logic                           busy_q;
	logic                           done_q;
	logic [NUM_CH-1:0][DIVD_W-1:0]  rem_nx;
	logic [NUM_CH-1:0]              fits;

	// one restoring step per lane, divisor walks right one bit per cycle while busy
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			fits[ch] = (CMP_W'(rem_q[ch]) >= CMP_W'(dsh_q[ch]));
			rem_nx[ch] = fits[ch] ? DIVD_W'(CMP_W'(rem_q[ch]) - CMP_W'(dsh_q[ch])) : rem_q[ch];
		end
	end

	// quotients of 256 or more saturate
	always_comb begin
		rsp.done = done_q;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			rsp.quot[ch] = quot_q[ch][QUOT_W-1] ? CH_MAX : quot_q[ch][CH_W-1:0];
		end
	end

	// sequencing of the nine quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsh_q  <= '0;
			quot_q <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					rem_q[ch] <= req.dividend[ch];
					dsh_q[ch] <= {req.divisor[ch], {CH_W{1'b0}}};
				end
				quot_q <= '0;
				step_q <= STEP_W'(QUOT_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					rem_q[ch]  <= rem_nx[ch];
					dsh_q[ch]  <= dsh_q[ch] >> 1;
					quot_q[ch] <= {quot_q[ch][QUOT_W-2:0], fits[ch]};
				end
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

endmodule

FILE: sv/gwwb_back.sv
module gwwb_back import gwwb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  item_t           item,
	input  logic            item_valid,
	output logic            item_pop,
	input  logic [CH_W-1:0] target_mean,
	output div_req_t        div_req,
	input  div_rsp_t        div_rsp,
	gwwb_res_if.source      result
);

	typedef enum logic {
		S_IDLE,
		S_DIV
	} state_t;

	state_t                         state_q;
	op_t                            op_q;
	logic [NUM_CH-1:0][TOTAL_W-1:0] tot_q;
	logic [COUNT_W-1:0]             cnt_q;
	logic                           clip_q;
	logic [NUM_CH-1:0][CH_W-1:0]    mean_q;
	logic                           out_valid_q;
	logic [NUM_CH-1:0][CH_W-1:0]    out_pix_q;
	logic                           out_clip_q;

	logic                           full;
	logic                           out_free;
	logic                           out_load;
	logic                           clip_nx;
	logic [COUNT_W-1:0]             cnt_nx;
	logic [NUM_CH-1:0][TOTAL_W-1:0] tot_nx;
	logic [NUM_CH-1:0][PROD_W-1:0]  prod;

	// gather update, dropped once the frame is at capacity
	always_comb begin
		full = cnt_q[PIXEL_COUNT_BITS];
		if (full) begin
			clip_nx = 1'b1;
		end else if (cnt_q == '0) begin
			clip_nx = 1'b0;
		end else begin
			clip_nx = clip_q;
		end
		cnt_nx = full ? cnt_q : cnt_q + COUNT_W'(1);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			tot_nx[ch] = full ? tot_q[ch] : tot_q[ch] + TOTAL_W'(item.pix[ch]);
			prod[ch] = PROD_W'(target_mean) * PROD_W'(item.pix[ch]);
		end
	end

	// dispatch: correct requests wait for a free output register
	always_comb begin
		out_free = !out_valid_q || result.ready;
		item_pop = (state_q == S_IDLE) && item_valid &&
			((item.op != OP_CORRECT) || out_free);
		div_req.start = item_pop && (item.op != OP_GATHER);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (item.op == OP_CORRECT) begin
				div_req.dividend[ch] = DIVD_W'(prod[ch]);
				div_req.divisor[ch]  = DVSR_W'(mean_q[ch]);
			end else begin
				div_req.dividend[ch] = DIVD_W'(tot_nx[ch]);
				div_req.divisor[ch]  = DVSR_W'(cnt_nx);
			end
		end
	end

	// a finished correct request loads the output register
	assign out_load = (state_q == S_DIV) && div_rsp.done && (op_q == OP_CORRECT);

	// control, statistics and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_GATHER;
			tot_q       <= '0;
			cnt_q       <= '0;
			clip_q      <= 1'b0;
			mean_q      <= {NUM_CH{MEAN_RESET}};
			out_valid_q <= 1'b0;
			out_pix_q   <= '0;
			out_clip_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_pop) begin
						op_q <= item.op;
						case (item.op)
							OP_GATHER: begin
								tot_q  <= tot_nx;
								cnt_q  <= cnt_nx;
								clip_q <= clip_nx;
							end
							OP_FINALIZE: begin
								clip_q  <= clip_nx;
								tot_q   <= '0;
								cnt_q   <= '0;
								state_q <= S_DIV;
							end
							OP_CORRECT: begin
								out_clip_q <= clip_q;
								state_q    <= S_DIV;
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (op_q == OP_FINALIZE) begin
							mean_q <= div_rsp.quot;
						end else begin
							out_pix_q <= div_rsp.quot;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.blue_out      = out_pix_q[CH_BLUE];
	assign result.green_out     = out_pix_q[CH_GREEN];
	assign result.red_out       = out_pix_q[CH_RED];
	assign result.frame_clipped = out_clip_q;

endmodule

FILE: sv/gray_world_white_balance_core.sv
// Gray-world white balance. Each frame is sent twice: gather requests
// (cmd 0) add a pixel to per-channel sums, and the one marked frame_last
// fixes the channel means as sum / count; correct requests (cmd 1) return
// target_mean * value / mean per channel, saturated at 255, with the
// clip flag of the last gathered frame. Means start at 128; a zero mean
// gives 255. A frame holds at most 2**PIXEL_COUNT_BITS pixels, extra
// pixels are dropped and flagged. A four-entry request queue decouples
// input from the processing unit. Correct and frame_last requests use the
// shared three-lane restoring divider, which retires one quotient bit per
// cycle over nine steps; no new request is taken until it is done. A
// correct request also waits until the output register is free. The user
// writes target_mean through the cfg channel only while no request is in
// flight; the block itself does not enforce this.
module gray_world_white_balance_core import gwwb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gwwb_pix_if.sink   pixel,
	gwwb_res_if.source result,
	gwwb_cfg_if.sink   cfg
);

	logic [CH_W-1:0] target_q;
	item_t           item;
	logic            item_valid;
	logic            item_pop;
	div_req_t        div_req;
	div_rsp_t        div_rsp;

	// configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg.valid && cfg.ready) begin
			target_q <= cfg.target_mean;
		end
	end

	gwwb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	gwwb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop),
		.target_mean (target_q),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.result      (result)
	);

	gwwb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
